[design/twtm_pkg.sv]
// Shared constants and codes for the tagged wildcard text matcher.
`timescale 1ns / 1ps
`default_nettype none
package twtm_pkg;

  // Store capacity and field widths
  localparam int MAX_LENGTH = 256;
  localparam int ADDR_W     = $clog2(MAX_LENGTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int TAG_BITS   = 8;
  localparam int WORD_BITS  = 16;
  localparam int KIND_W     = 2;
  localparam int OP_W       = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_RAW_W   = OP_W + TAG_BITS + WORD_BITS + KIND_W;
  localparam int IN_W       = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_W      = 8;

  // Stored entry widths
  localparam int TEXT_W     = TAG_BITS + WORD_BITS;
  localparam int PAT_W      = KIND_W + TAG_BITS + WORD_BITS;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_TEXT  = 2'd1,
    OP_PAT   = 2'd2,
    OP_EVAL  = 2'd3
  } op_e_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_VAR  = 2'd0,
    KIND_TAG  = 2'd1,
    KIND_WORD = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

endpackage
`default_nettype wire

[design/tagged_wildcard_text_matcher.sv]
// Top level: text and pattern stores and the reach-row evaluation sweep.
//
//  channel | dir | payload (low bit up)                                   | transfer
//  in_     | in  | opcode[1:0] tag[9:2] word_id[25:10] unit_kind[27:26]   | tvalid & tready
//  out_    | out | matched[0] overflowed[1]                               | tvalid & tready
//
// Clear and append leave the matcher idle; a new item is taken in the next cycle.
// Evaluate sweeps the n text tokens once for each of the m pattern units when the
// trivial checks pass, else goes straight to the finish state: one reach-row RAM
// read-modify-write per cell, plus one pattern fetch per row.
// Reset clears the lengths, the overflow flag and the output; stores keep data.
// Input is taken only while no evaluation runs; the result register lets loads
// proceed while a result waits on out_tready.
`timescale 1ns / 1ps
`default_nettype none
module tagged_wildcard_text_matcher (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  output logic                           in_tready,
  // opcode[1:0], tag[9:2], word_id[25:10], unit_kind[27:26], zero pad
  input  wire logic [twtm_pkg::IN_W-1:0] in_tdata,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  // matched[0], overflowed[1], zero pad
  output logic [twtm_pkg::OUT_W-1:0]     out_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SWEEP,
    ST_FIN
  } state_t;

  state_t                           state_r;
  logic [twtm_pkg::LEN_W-1:0]       text_len_r;
  logic [twtm_pkg::LEN_W-1:0]       pat_len_r;
  logic                             ovf_r;
  logic [twtm_pkg::ADDR_W-1:0]      col_r;      // text address under processing
  logic [twtm_pkg::ADDR_W-1:0]      row_r;      // pattern unit index
  logic                             new_prev_r; // new reach at previous column
  logic                             old_prev_r; // old reach at previous column
  logic                             match_r;
  logic                             out_valid_r;
  logic                             out_match_r;
  logic                             out_ovf_r;

  // Input field split
  twtm_pkg::op_e_t                  in_op;
  logic [twtm_pkg::TAG_BITS-1:0]    in_tag;
  logic [twtm_pkg::WORD_BITS-1:0]   in_word;
  logic [twtm_pkg::KIND_W-1:0]      in_kind;
  logic                             in_fire;

  assign in_op   = twtm_pkg::op_e_t'(in_tdata[1:0]);
  assign in_tag  = in_tdata[2 +: twtm_pkg::TAG_BITS];
  assign in_word = in_tdata[2 + twtm_pkg::TAG_BITS +: twtm_pkg::WORD_BITS];
  assign in_kind = in_tdata[2 + twtm_pkg::TAG_BITS + twtm_pkg::WORD_BITS +: twtm_pkg::KIND_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;

  // Store write control
  logic text_full, pat_full, text_we, pat_we;

  assign text_full = (text_len_r == twtm_pkg::LEN_W'(twtm_pkg::MAX_LENGTH));
  assign pat_full  = (pat_len_r == twtm_pkg::LEN_W'(twtm_pkg::MAX_LENGTH));
  assign text_we   = in_fire && (in_op == twtm_pkg::OP_TEXT) && !text_full;
  assign pat_we    = in_fire && (in_op == twtm_pkg::OP_PAT) && !pat_full;

  // Read address: first column in prep, next column during the sweep
  logic [twtm_pkg::ADDR_W-1:0] rd_addr;

  assign rd_addr = (state_r == ST_SWEEP) ? twtm_pkg::ADDR_W'(col_r + 1'b1) : '0;

  logic [twtm_pkg::TEXT_W-1:0] text_rdata;
  logic [twtm_pkg::PAT_W-1:0]  pat_rdata;
  logic                        reach_rdata;
  logic                        reach_we;
  logic                        cell_val;

  twtm_ram #(
    .WIDTH (twtm_pkg::TEXT_W),
    .DEPTH (twtm_pkg::MAX_LENGTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (text_we),
    .waddr (text_len_r[twtm_pkg::ADDR_W-1:0]),
    .wdata ({in_word, in_tag}),
    .raddr (rd_addr),
    .rdata (text_rdata)
  );

  twtm_ram #(
    .WIDTH (twtm_pkg::PAT_W),
    .DEPTH (twtm_pkg::MAX_LENGTH)
  ) u_pat_ram (
    .clk   (clk),
    .we    (pat_we),
    .waddr (pat_len_r[twtm_pkg::ADDR_W-1:0]),
    .wdata ({in_word, in_tag, in_kind}),
    .raddr (row_r),
    .rdata (pat_rdata)
  );

  twtm_ram #(
    .WIDTH (1),
    .DEPTH (twtm_pkg::MAX_LENGTH)
  ) u_reach_ram (
    .clk   (clk),
    .we    (reach_we),
    .waddr (col_r),
    .wdata (cell_val),
    .raddr (rd_addr),
    .rdata (reach_rdata)
  );

  // Cell update: reach at column col_r+1 after this pattern unit
  twtm_pkg::kind_t                p_kind;
  logic [twtm_pkg::TAG_BITS-1:0]  p_tag, t_tag;
  logic [twtm_pkg::WORD_BITS-1:0] p_word, t_word;
  logic                           first_row, old_here, unit_hit;
  logic                           last_col, last_row, trivial_miss;

  assign p_kind = twtm_pkg::kind_t'(pat_rdata[twtm_pkg::KIND_W-1:0]);
  assign p_tag  = pat_rdata[twtm_pkg::KIND_W +: twtm_pkg::TAG_BITS];
  assign p_word = pat_rdata[twtm_pkg::KIND_W + twtm_pkg::TAG_BITS +: twtm_pkg::WORD_BITS];
  assign t_tag  = text_rdata[twtm_pkg::TAG_BITS-1:0];
  assign t_word = text_rdata[twtm_pkg::TAG_BITS +: twtm_pkg::WORD_BITS];

  assign first_row = (row_r == '0);
  assign old_here  = first_row ? 1'b0 : reach_rdata;
  assign unit_hit  = (t_tag == p_tag) &&
                     ((p_kind == twtm_pkg::KIND_TAG) ||
                      ((p_kind == twtm_pkg::KIND_WORD) && (t_word == p_word)));
  assign cell_val  = (p_kind == twtm_pkg::KIND_VAR) ? (new_prev_r || old_prev_r)
                                                    : (old_prev_r && unit_hit);
  assign reach_we  = (state_r == ST_SWEEP);

  assign last_col     = (twtm_pkg::LEN_W'(col_r) + 1'b1 == text_len_r);
  assign last_row     = (twtm_pkg::LEN_W'(row_r) + 1'b1 == pat_len_r);
  assign trivial_miss = ovf_r || (pat_len_r == '0) || (text_len_r < pat_len_r);

  // Control, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      text_len_r  <= '0;
      pat_len_r   <= '0;
      ovf_r       <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      new_prev_r  <= 1'b0;
      old_prev_r  <= 1'b0;
      match_r     <= 1'b0;
      out_valid_r <= 1'b0;
      out_match_r <= 1'b0;
      out_ovf_r   <= 1'b0;
    end else begin
      // Drop the result once taken, unless the finish state refills it
      if (out_valid_r && out_tready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_op)
              twtm_pkg::OP_CLEAR: begin
                text_len_r <= '0;
                pat_len_r  <= '0;
                ovf_r      <= 1'b0;
              end
              twtm_pkg::OP_TEXT: begin
                if (text_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  text_len_r <= text_len_r + 1'b1;
                end
              end
              twtm_pkg::OP_PAT: begin
                if (pat_full) begin
                  ovf_r <= 1'b1;
                end else begin
                  pat_len_r <= pat_len_r + 1'b1;
                end
              end
              twtm_pkg::OP_EVAL: begin
                row_r <= '0;
                if (trivial_miss) begin
                  match_r <= 1'b0;
                  state_r <= ST_FIN;
                end else begin
                  state_r <= ST_PREP;
                end
              end
              default: ;
            endcase
          end
        end
        ST_PREP: begin
          // Pattern unit and first column are being fetched
          col_r      <= '0;
          new_prev_r <= 1'b0;
          old_prev_r <= first_row;
          state_r    <= ST_SWEEP;
        end
        ST_SWEEP: begin
          new_prev_r <= cell_val;
          old_prev_r <= old_here;
          if (last_col) begin
            if (last_row) begin
              match_r <= cell_val;
              state_r <= ST_FIN;
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= ST_PREP;
            end
          end else begin
            col_r <= col_r + 1'b1;
          end
        end
        ST_FIN: begin
          // Hand the result over once the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_match_r <= match_r;
            out_ovf_r   <= ovf_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(twtm_pkg::OUT_W-2){1'b0}}, out_ovf_r, out_match_r};

  // Checks
  a_text_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
    text_len_r <= twtm_pkg::LEN_W'(twtm_pkg::MAX_LENGTH))
    else $error("text length beyond capacity");

  a_col_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (twtm_pkg::LEN_W'(col_r) < text_len_r))
    else $error("sweep column beyond text length");

  a_row_in_pat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PREP || state_r == ST_SWEEP) |->
      (twtm_pkg::LEN_W'(row_r) < pat_len_r))
    else $error("pattern row beyond pattern length");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result raised outside finish state");

  a_no_overlap_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP && last_col && last_row) |=> (state_r == ST_FIN))
    else $error("sweep end did not reach finish state");

endmodule
`default_nettype wire

[design/twtm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module twtm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
